// ----- src/rpot_pkg.sv -----
package rpot_pkg;

  localparam int PAGE_SHIFT         = 21;
  localparam int PAGES_PER_REGION   = 32;
  localparam int REGION_SHIFT       = 26;
  localparam int PAGE_FIELD_W       = REGION_SHIFT - PAGE_SHIFT;
  localparam int TAG_W              = 32 - REGION_SHIFT;
  localparam int MAP_W              = 32;
  localparam int SIZE_W             = 27;
  localparam int REGION_ENTRIES_DEF = 16;

  localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(1 << REGION_SHIFT);

  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_IN_USE       = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
  localparam logic [2:0] ST_ALREADY_FREE = 3'd3;
  localparam logic [2:0] ST_FULL         = 3'd4;

  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_DEL = 1'b1;

  typedef struct packed {
    logic capture;
    logic scan_step;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } sts_t;

  // pages from round-up of offset, spanning size rounded up to pages
  function automatic logic [MAP_W-1:0] build_mask(
    input logic [REGION_SHIFT-1:0] offset,
    input logic [SIZE_W-1:0]       size
  );
    logic [PAGE_FIELD_W:0]   first;
    logic [PAGE_FIELD_W:0]   count;
    logic [PAGE_FIELD_W+1:0] stop;
    logic [MAP_W-1:0]        mask;
    first = {1'b0, offset[REGION_SHIFT-1:PAGE_SHIFT]}
          + (PAGE_FIELD_W+1)'(|offset[PAGE_SHIFT-1:0]);
    if (size >= SIZE_LIMIT) begin
      count = (PAGE_FIELD_W+1)'(PAGES_PER_REGION);
    end else begin
      count = {1'b0, size[REGION_SHIFT-1:PAGE_SHIFT]}
            + (PAGE_FIELD_W+1)'(|size[PAGE_SHIFT-1:0]);
    end
    stop = {1'b0, first} + {1'b0, count};
    for (int i = 0; i < MAP_W; i++) begin
      mask[i] = ((PAGE_FIELD_W+2)'(i) >= {1'b0, first}) && ((PAGE_FIELD_W+2)'(i) < stop);
    end
    return mask;
  endfunction

endpackage

// ----- src/rpot_ram.sv -----
module rpot_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
  )
  (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/rpot_ctrl.sv -----
module rpot_ctrl
  import rpot_pkg::*;
  (
    input  logic clk,
    input  logic rst,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
  );

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_UPDATE = 4'b0100,
    S_OUT    = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next    = state;
    cmd.capture   = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.update    = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_UPDATE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

endmodule

// ----- src/rpot_datapath.sv -----
module rpot_datapath
  import rpot_pkg::*;
  #(
    parameter int REGION_ENTRIES = REGION_ENTRIES_DEF
  )
  (
    input  logic              clk,
    input  logic              rst,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic              func,
    input  logic [31:0]       address,
    input  logic [SIZE_W-1:0] byte_size,
    output logic [2:0]        status,
    output logic [MAP_W-1:0]  page_mask,
    output logic [MAP_W-1:0]  region_map
  );

  localparam int IDX_W = (REGION_ENTRIES > 1) ? $clog2(REGION_ENTRIES) : 1;
  localparam int ENT_W = TAG_W + MAP_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(REGION_ENTRIES - 1);

  logic                      cap_func;
  logic [TAG_W-1:0]          cap_tag;
  logic [MAP_W-1:0]          cap_mask;
  logic [IDX_W-1:0]          scan_idx;
  logic [IDX_W-1:0]          rd_idx;
  logic                      pend;
  logic                      hit;
  logic [IDX_W-1:0]          hit_idx;
  logic [MAP_W-1:0]          hit_map;
  logic                      free_found;
  logic [IDX_W-1:0]          free_idx;
  logic [REGION_ENTRIES-1:0] valid;

  logic [ENT_W-1:0] rdata;
  logic [TAG_W-1:0] rd_tag;
  logic [MAP_W-1:0] rd_map;

  logic [IDX_W-1:0] ent;
  logic [MAP_W-1:0] cur_map;
  logic [MAP_W-1:0] new_map;
  logic [MAP_W-1:0] map_out;
  logic [2:0]       st;
  logic             wr_en;
  logic             v_set;
  logic             v_clr;

  assign rd_tag = rdata[ENT_W-1:MAP_W];
  assign rd_map = rdata[MAP_W-1:0];

  rpot_ram #(
    .WIDTH (ENT_W),
    .DEPTH (REGION_ENTRIES),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(ent),
    .wdata({cap_tag, new_map}),
    .raddr(scan_idx),
    .rdata(rdata)
  );

  assign sts.scan_done = pend && (rd_idx == LAST);

  // capture, then scan one entry a cycle against the registered read data
  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 1'b0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      scan_idx   <= '0;
    end else begin
      pend <= cmd.scan_step;
      if (cmd.capture) begin
        scan_idx   <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          scan_idx <= scan_idx + IDX_W'(1);
        end
        if (pend) begin
          if (valid[rd_idx] && (rd_tag == cap_tag) && !hit) begin
            hit <= 1'b1;
          end
          if (!valid[rd_idx] && !free_found) begin
            free_found <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_func <= func;
      cap_tag  <= address[31:REGION_SHIFT];
      cap_mask <= build_mask(address[REGION_SHIFT-1:0], byte_size);
    end
    if (cmd.scan_step) begin
      rd_idx <= scan_idx;
    end
    if (pend && !cmd.capture) begin
      if (valid[rd_idx] && (rd_tag == cap_tag) && !hit) begin
        hit_idx <= rd_idx;
        hit_map <= rd_map;
      end
      if (!valid[rd_idx] && !free_found) begin
        free_idx <= rd_idx;
      end
    end
  end

  assign ent     = hit ? hit_idx : free_idx;
  assign cur_map = hit ? hit_map : '0;

  always_comb begin
    wr_en   = 1'b0;
    v_set   = 1'b0;
    v_clr   = 1'b0;
    new_map = cur_map;
    map_out = '0;
    st      = ST_OK;
    if (cap_func == FUNC_ADD) begin
      if (!hit && !free_found) begin
        st = ST_FULL;
      end else if ((cur_map & cap_mask) != '0) begin
        st      = ST_IN_USE;
        map_out = cur_map;
      end else begin
        new_map = cur_map | cap_mask;
        map_out = new_map;
        wr_en   = cmd.update;
        v_set   = cmd.update;
      end
    end else begin
      if (!hit) begin
        st = ST_NOT_FOUND;
      end else if ((cur_map & cap_mask) == '0) begin
        st      = ST_ALREADY_FREE;
        map_out = cur_map;
      end else begin
        new_map = cur_map & ~cap_mask;
        map_out = new_map;
        wr_en   = cmd.update;
        // entry is released once its map is empty
        v_clr   = cmd.update && (new_map == '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (v_clr) begin
      valid[ent] <= 1'b0;
    end else if (v_set) begin
      valid[ent] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      status     <= st;
      page_mask  <= cap_mask;
      region_map <= map_out;
    end
  end

endmodule

// ----- src/region_page_occupancy_tracker.sv -----
// an accepted item is captured, every table entry is scanned, then the result is registered and held until taken
// the tag scan reads one table entry per cycle through the single ram read port
// in_ready only while idle, so a new item is not taken until the last result is taken
// the next item is taken the cycle after the result is taken
// reset (rst, synchronous) returns to idle and clears all entry valid bits
module region_page_occupancy_tracker
  import rpot_pkg::*;
  #(
    parameter int REGION_ENTRIES = REGION_ENTRIES_DEF
  )
  (
    input  logic              clk,
    input  logic              rst,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [31:0]       address,
    input  logic [SIZE_W-1:0] byte_size,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        status,
    output logic [MAP_W-1:0]  page_mask,
    output logic [MAP_W-1:0]  region_map
  );

  cmd_t cmd;
  sts_t sts;

  rpot_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rpot_datapath #(
    .REGION_ENTRIES(REGION_ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .func      (func),
    .address   (address),
    .byte_size (byte_size),
    .status    (status),
    .page_mask (page_mask),
    .region_map(region_map)
  );

endmodule

// ----- tb/rpot_occupancy_checker.sv -----
`timescale 1ns / 1ps

module rpot_occupancy_checker
  import rpot_pkg::*;
  #(
    parameter int ENTRIES = REGION_ENTRIES_DEF
  )
  (
    input  logic              clk,
    input  logic              rst,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              func,
    input  logic [31:0]       address,
    input  logic [SIZE_W-1:0] byte_size,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [2:0]        status,
    input  logic [MAP_W-1:0]  page_mask,
    input  logic [MAP_W-1:0]  region_map,
    output int                mismatches,
    output int                outstanding
  );

  typedef struct packed {
    logic [2:0]       status;
    logic [MAP_W-1:0] mask;
    logic [MAP_W-1:0] map;
  } occupancy_t;

  logic             slot_busy  [ENTRIES];
  logic [TAG_W-1:0] slot_tag   [ENTRIES];
  logic [MAP_W-1:0] slot_pages [ENTRIES];

  occupancy_t pending_outcomes[$];

  // pages covered: start rounded up to a page, length rounded up to pages
  function automatic logic [MAP_W-1:0] pages_touched(input logic [31:0] addr,
                                                     input logic [SIZE_W-1:0] len);
    int unsigned offs;
    int unsigned sz;
    int unsigned first_pg;
    int unsigned n_pg;
    logic [MAP_W-1:0] m;
    offs = 32'(addr[REGION_SHIFT-1:0]);
    sz = 32'((len > SIZE_LIMIT) ? SIZE_LIMIT : len);
    first_pg = (offs + (1 << PAGE_SHIFT) - 1) >> PAGE_SHIFT;
    n_pg = (sz + (1 << PAGE_SHIFT) - 1) >> PAGE_SHIFT;
    m = '0;
    for (int unsigned i = 0; i < MAP_W && i < PAGES_PER_REGION; i++) begin
      if (i >= first_pg && i - first_pg < n_pg) m[i] = 1'b1;
    end
    return m;
  endfunction

  function automatic occupancy_t track_request(input logic f, input logic [31:0] addr,
                                               input logic [SIZE_W-1:0] len);
    occupancy_t r;
    logic [TAG_W-1:0] tag;
    int slot;
    tag = addr[31:REGION_SHIFT];
    r.mask = pages_touched(addr, len);
    r.map = '0;
    slot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot < 0 && slot_busy[i] && slot_tag[i] == tag) slot = i;
    end
    if (f == FUNC_ADD) begin
      // unknown region opens the lowest free entry, even for an empty mask
      if (slot < 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot < 0 && !slot_busy[i]) slot = i;
        end
        if (slot >= 0) begin
          slot_busy[slot]  = 1'b1;
          slot_tag[slot]   = tag;
          slot_pages[slot] = '0;
        end
      end
      if (slot < 0) begin
        r.status = ST_FULL;
      end else if ((slot_pages[slot] & r.mask) != '0) begin
        r.status = ST_IN_USE;
        r.map = slot_pages[slot];
      end else begin
        slot_pages[slot] = slot_pages[slot] | r.mask;
        r.status = ST_OK;
        r.map = slot_pages[slot];
      end
    end else begin
      if (slot < 0) begin
        r.status = ST_NOT_FOUND;
      end else if ((slot_pages[slot] & r.mask) == '0) begin
        r.status = ST_ALREADY_FREE;
        r.map = slot_pages[slot];
      end else begin
        slot_pages[slot] = slot_pages[slot] & ~r.mask;
        r.status = ST_OK;
        r.map = slot_pages[slot];
        if (r.map == '0) slot_busy[slot] = 1'b0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    occupancy_t want;
    if (rst) begin
      for (int i = 0; i < ENTRIES; i++) slot_busy[i] = 1'b0;
      pending_outcomes.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result item with nothing expected, status %0d mask %h map %h",
                   $time, status, page_mask, region_map);
          mismatches++;
        end else begin
          want = pending_outcomes.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d, actual %0d", $time, want.status, status);
            mismatches++;
          end
          if (page_mask !== want.mask) begin
            $display("%0t: page_mask expected %h, actual %h", $time, want.mask, page_mask);
            mismatches++;
          end
          if (region_map !== want.map) begin
            $display("%0t: region_map expected %h, actual %h", $time, want.map, region_map);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_outcomes.push_back(track_request(func, address, byte_size));
      end
    end
    outstanding <= pending_outcomes.size();
  end

endmodule

// ----- tb/tb_region_page_occupancy_tracker.sv -----
`timescale 1ns / 1ps

module tb_region_page_occupancy_tracker;
  import rpot_pkg::*;

  localparam int          RANDOM_ITEMS = 550;
  localparam int unsigned CYCLE_LIMIT  = 250000;
  localparam int          HOT_COUNT    = 22;
  localparam logic [31:0] PAGE_BYTES   = 32'(1) << PAGE_SHIFT;
  localparam logic [31:0] REGION_BYTES = 32'(1) << REGION_SHIFT;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              func = FUNC_ADD;
  logic [31:0]       address = '0;
  logic [SIZE_W-1:0] byte_size = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        status;
  logic [MAP_W-1:0]  page_mask;
  logic [MAP_W-1:0]  region_map;

  logic        calm = 1'b0;
  int unsigned cycle_count = 0;
  int          mismatches;
  int          outstanding;

  logic [TAG_W-1:0] hot_tags [HOT_COUNT];

  region_page_occupancy_tracker u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .address    (address),
    .byte_size  (byte_size),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .page_mask  (page_mask),
    .region_map (region_map)
  );

  rpot_occupancy_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .func        (func),
    .address     (address),
    .byte_size   (byte_size),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .page_mask   (page_mask),
    .region_map  (region_map),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  // offers one item and returns at the edge where it is taken
  task automatic offer(input logic f, input logic [31:0] a, input logic [SIZE_W-1:0] s);
    if (!calm && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(0, 99) < 28) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    address   <= a;
    byte_size <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    logic              f;
    logic [31:0]       a;
    logic [SIZE_W-1:0] s;
    logic [TAG_W-1:0]  tag;
    logic [4:0]        pg;
    int                pick;

    for (int i = 0; i < 17; i++) hot_tags[i] = TAG_W'(i);
    hot_tags[17] = TAG_W'(63);
    hot_tags[18] = TAG_W'(62);
    hot_tags[19] = TAG_W'(31);
    hot_tags[20] = TAG_W'(32);
    hot_tags[21] = TAG_W'(45);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // empty mask still opens an entry, then a whole-region add and an overlap
    offer(FUNC_ADD, 32'h0000_0000, SIZE_W'(0));
    offer(FUNC_ADD, 32'h0000_0000, SIZE_W'(REGION_BYTES));
    offer(FUNC_ADD, 32'h0020_0000, SIZE_W'(1));
    offer(FUNC_DEL, 32'h0040_0000, SIZE_W'(2 * PAGE_BYTES));
    offer(FUNC_DEL, 32'h0040_0000, SIZE_W'(2 * PAGE_BYTES));
    // unaligned start rounds up, oversized length saturates
    offer(FUNC_DEL, 32'h01FF_FFFF, {SIZE_W{1'b1}});
    offer(FUNC_DEL, 32'h0000_0000, SIZE_W'(0));
    offer(FUNC_DEL, 32'hFC00_0000, SIZE_W'(PAGE_BYTES));
    // start rounds past the region end: nothing in the mask
    offer(FUNC_ADD, 32'hFFFF_FFFF, {SIZE_W{1'b1}});
    offer(FUNC_ADD, 32'hFC00_0001, SIZE_W'(PAGE_BYTES + 1));
    offer(FUNC_DEL, 32'hFC00_0000, SIZE_W'(REGION_BYTES));
    offer(FUNC_DEL, 32'h0000_0000, SIZE_W'(REGION_BYTES));
    // fill every entry, then one region too many
    for (int i = 1; i <= 16; i++) offer(FUNC_ADD, 32'(i) << REGION_SHIFT, SIZE_W'(1));
    offer(FUNC_ADD, 32'h4400_0000, SIZE_W'(PAGE_BYTES));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm <= (n >= 250 && n < 350);
      pick = $urandom_range(0, 99);
      f = logic'($urandom_range(0, 1));
      if (pick < 85) begin
        tag = hot_tags[$urandom_range(0, HOT_COUNT - 1)];
        pg = 5'($urandom_range(0, 31));
        a = {tag, pg, {PAGE_SHIFT{1'b0}}};
        if ($urandom_range(0, 3) == 0) a[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom);
        s = SIZE_W'($urandom_range(1, 4)) << PAGE_SHIFT;
        if ($urandom_range(0, 3) == 0) s = s - SIZE_W'($urandom_range(1, PAGE_BYTES - 1));
        // occasional whole-region release keeps entries turning over
        if (f == FUNC_DEL && $urandom_range(0, 9) == 0) begin
          a[REGION_SHIFT-1:0] = '0;
          s = SIZE_W'(REGION_BYTES);
        end
      end else begin
        a = $urandom;
        s = SIZE_W'($urandom);
      end
      offer(f, a, s);
    end
    in_valid <= 1'b0;
    calm <= 1'b0;

    // let the checker count the last item before waiting for it to drain
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (REGION_ENTRIES_DEF + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
